/* rtl/core/npcs_pkg.sv */
// ----------------------------------------------------------------------------
// npcs_pkg
// Shared types and constants for the nearest palette color search block.
// ----------------------------------------------------------------------------
package npcs_pkg;

	localparam int CHAN6_W   = 6;
	localparam int CHAN8_W   = 8;
	localparam int INDEX_W   = 8;
	localparam int ENTRY_W   = 3 * CHAN6_W;
	localparam int SQ_W      = 2 * CHAN8_W;
	localparam int DIST_W    = 18;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 32;

	// Request kinds carried on the input side band.
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} npcs_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr_en;
		logic start;
		logic issue;
		logic load_out;
	} npcs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last_addr;
		logic pipe_busy;
		logic out_busy;
	} npcs_sts_t;

endpackage

/* rtl/core/npcs_ram.sv */
// ----------------------------------------------------------------------------
// npcs_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module npcs_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

/* rtl/core/npcs_dp.sv */
// ----------------------------------------------------------------------------
// npcs_dp
// Datapath: palette memory, scan address counter, distance pipeline,
// running minimum and the output register.
// ----------------------------------------------------------------------------
module npcs_dp import npcs_pkg::*; #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  npcs_cmd_t            cmd,
	output npcs_sts_t            sts,
	input  logic [INDEX_W-1:0]   entry_index,
	input  logic [CHAN6_W-1:0]   entry_red6,
	input  logic [CHAN6_W-1:0]   entry_green6,
	input  logic [CHAN6_W-1:0]   entry_blue6,
	input  logic [CHAN8_W-1:0]   query_red,
	input  logic [CHAN8_W-1:0]   query_green,
	input  logic [CHAN8_W-1:0]   query_blue,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [INDEX_W-1:0]   best_index,
	output logic [DIST_W-1:0]    best_distance
);

	localparam int AW = $clog2(PALETTE_ENTRIES);
	localparam logic [AW-1:0]    LAST_ADDR   = AW'(PALETTE_ENTRIES - 1);
	localparam logic [AW-1:0]    FIRST_ADDR  = AW'(1);
	localparam logic [INDEX_W:0] ENTRY_LIMIT = (INDEX_W + 1)'(PALETTE_ENTRIES);

	function automatic logic [CHAN8_W-1:0] widen6(input logic [CHAN6_W-1:0] v);
		widen6 = {v, v[CHAN6_W-1 -: 2]};
	endfunction

	function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN8_W-1:0] a,
	                                            input logic [CHAN8_W-1:0] b);
		logic [CHAN8_W-1:0] d;
		d = (a >= b) ? (a - b) : (b - a);
		sq_diff = SQ_W'(d) * SQ_W'(d);
	endfunction

	logic [CHAN8_W-1:0] qr_q, qg_q, qb_q;
	logic [AW-1:0]      addr_q;
	logic               wr_ok;
	logic [ENTRY_W-1:0] rd_data;

	logic               v_s1, v_s2;
	logic [AW-1:0]      idx_s1, idx_s2;
	logic [SQ_W-1:0]    sqr_s2, sqg_s2, sqb_s2;
	logic [DIST_W-1:0]  cand_dist;

	logic [AW-1:0]      best_idx_q;
	logic [DIST_W-1:0]  best_dist_q;
	logic               out_valid_q;
	logic [INDEX_W-1:0] out_index_q;
	logic [DIST_W-1:0]  out_dist_q;

	assign wr_ok = cmd.wr_en && ({1'b0, entry_index} < ENTRY_LIMIT);

	npcs_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (PALETTE_ENTRIES)
	) u_palette (
		.clk     (clk),
		.wr_en   (wr_ok),
		.wr_addr (entry_index[AW-1:0]),
		.wr_data ({entry_red6, entry_green6, entry_blue6}),
		.rd_addr (addr_q),
		.rd_data (rd_data)
	);

	// Query color and scan address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= FIRST_ADDR;
		end else if (cmd.start) begin
			addr_q <= FIRST_ADDR;
		end else if (cmd.issue) begin
			addr_q <= addr_q + FIRST_ADDR;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			qr_q <= query_red;
			qg_q <= query_green;
			qb_q <= query_blue;
		end
	end

	// Pipeline valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	// Stage 1: memory read returns; stage 2: per-channel squares.
	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		idx_s2 <= idx_s1;
		sqr_s2 <= sq_diff(widen6(rd_data[3*CHAN6_W-1 -: CHAN6_W]), qr_q);
		sqg_s2 <= sq_diff(widen6(rd_data[2*CHAN6_W-1 -: CHAN6_W]), qg_q);
		sqb_s2 <= sq_diff(widen6(rd_data[CHAN6_W-1:0]), qb_q);
	end

	assign cand_dist = DIST_W'(sqr_s2) + DIST_W'(sqg_s2) + DIST_W'(sqb_s2);

	// Running minimum; only a strictly smaller distance replaces the best.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			best_idx_q  <= FIRST_ADDR;
			best_dist_q <= '1;
		end else if (v_s2 && (cand_dist < best_dist_q)) begin
			best_idx_q  <= idx_s2;
			best_dist_q <= cand_dist;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_index_q <= INDEX_W'(best_idx_q);
			out_dist_q  <= best_dist_q;
		end
	end

	assign sts.last_addr = (addr_q == LAST_ADDR);
	assign sts.pipe_busy = v_s1 || v_s2;
	assign sts.out_busy  = out_valid_q && !out_ready;

	assign out_valid     = out_valid_q;
	assign best_index    = out_index_q;
	assign best_distance = out_dist_q;

endmodule

/* rtl/core/npcs_ctrl.sv */
// ----------------------------------------------------------------------------
// npcs_ctrl
// Controller: takes input transactions, sequences the palette scan and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module npcs_ctrl import npcs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_kind,
	output logic      in_ready,
	input  npcs_sts_t sts,
	output npcs_cmd_t cmd
);

	npcs_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_kind == REQ_QUERY) begin
						cmd.start = 1'b1;
						state_d   = ST_SCAN;
					end else begin
						cmd.wr_en = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.last_addr) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy && !sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/nearest_palette_color_search.sv */
// ----------------------------------------------------------------------------
// nearest_palette_color_search
// Palette of six-bit RGB entries with a nearest-color query.
// ----------------------------------------------------------------------------
// The block keeps a palette of PALETTE_ENTRIES six-bit RGB entries in a
// single-port-write, registered-read memory. A write transaction
// (s_axis_tuser low) stores one entry and produces no output;
// a write whose index is beyond the palette is dropped. A query transaction
// (s_axis_tuser high) widens every stored channel to eight bits by bit
// replication and scans entries 1 to PALETTE_ENTRIES-1 in rising order,
// returning the index with the smallest squared Euclidean distance to the
// query color and that distance; on a tie the lower index wins and entry 0
// is never chosen. The scan reads one memory word per cycle, so a query
// holds the input while it reads entries 1 to PALETTE_ENTRIES-1 and drains
// the read and distance pipeline; s_axis_tready is low during that time.
// The result sits in an output register, so new writes and the next query
// are taken while a finished result still waits on m_axis_tready; a scan
// that finishes while that register is still full waits for it to empty.
// Entries must be written before a query reads them: the memory is not
// cleared at reset, and a query over unwritten entries returns undefined
// values.
// ----------------------------------------------------------------------------
module nearest_palette_color_search import npcs_pkg::*; #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// tdata, lowest bit up: entry_index[7:0], entry_red6[5:0],
	// entry_green6[5:0], entry_blue6[5:0], query_red[7:0], query_green[7:0],
	// query_blue[7:0], zero padding.
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// tuser: req_type (0 writes an entry, 1 queries).
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// tdata, lowest bit up: best_index[7:0], best_distance[17:0], zero padding.
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	npcs_cmd_t          cmd;
	npcs_sts_t          sts;
	logic [INDEX_W-1:0] best_index;
	logic [DIST_W-1:0]  best_distance;

	// The controller sequences writes, the scan and the hand-off of the result.
	npcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_kind  (s_axis_tuser),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath unpacks the input fields straight from tdata.
	npcs_dp #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.entry_index   (s_axis_tdata[7:0]),
		.entry_red6    (s_axis_tdata[13:8]),
		.entry_green6  (s_axis_tdata[19:14]),
		.entry_blue6   (s_axis_tdata[25:20]),
		.query_red     (s_axis_tdata[33:26]),
		.query_green   (s_axis_tdata[41:34]),
		.query_blue    (s_axis_tdata[49:42]),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.best_index    (best_index),
		.best_distance (best_distance)
	);

	assign m_axis_tdata = {{(OUT_DATA_W - INDEX_W - DIST_W){1'b0}}, best_distance, best_index};

endmodule

/* verif/nearest_palette_color_search_tb.sv */
// ----------------------------------------------------------------------------
// nearest_palette_color_search_tb
// Self-checking bench for the nearest palette color search block.
// ----------------------------------------------------------------------------
// The bench first loads every palette entry, so no query ever reads an entry
// that was never written. It then runs directed queries on the distance
// extremes, on ties and on entry 0, and finishes with random write and query
// traffic. A local shadow of the palette predicts each query result when
// the query transaction is accepted. A monitor compares every output
// transaction with the oldest prediction. Both stream sides idle at random,
// except for one stretch with no idling at all.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_tb;
	import npcs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAL_N       = 256;
	localparam int STALL_LIMIT = 8 * (PAL_N + 3);
	localparam int IDLE_PCT    = 28;

	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic [DIST_W-1:0]  distance;
	} color_match_t;

	logic                  clk;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic                  s_axis_tuser  = REQ_WRITE;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// Shadow palette, packed as red, green, blue from the top down.
	logic [ENTRY_W-1:0] shade_table [PAL_N];
	color_match_t       pending_matches [$];
	int                 error_count  = 0;
	int                 quiet_cycles = 0;
	bit                 steady       = 1'b0;

	nearest_palette_color_search #(
		.PALETTE_ENTRIES(PAL_N)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	// Six-bit channel to eight bits by repeating the top bits at the bottom.
	function automatic logic [CHAN8_W-1:0] widen_channel(input logic [CHAN6_W-1:0] v);
		return {v, v[CHAN6_W-1 -: 2]};
	endfunction

	function automatic int channel_error(input logic [CHAN8_W-1:0] a,
			input logic [CHAN8_W-1:0] b);
		int d;
		d = int'(a) - int'(b);
		return d * d;
	endfunction

	// Scan entries 1 and up; only a strictly smaller distance wins, so ties
	// keep the lower index and entry 0 is never a candidate.
	function automatic color_match_t find_nearest(input logic [CHAN8_W-1:0] qr,
			input logic [CHAN8_W-1:0] qg, input logic [CHAN8_W-1:0] qb);
		color_match_t       best;
		int                 best_dist;
		int                 cand_dist;
		logic [ENTRY_W-1:0] e;
		best.index = INDEX_W'(1);
		best_dist  = 32'h7fff_ffff;
		for (int i = 1; i < PAL_N; i++) begin
			e         = shade_table[i];
			cand_dist = channel_error(widen_channel(e[3*CHAN6_W-1 -: CHAN6_W]), qr)
			          + channel_error(widen_channel(e[2*CHAN6_W-1 -: CHAN6_W]), qg)
			          + channel_error(widen_channel(e[CHAN6_W-1:0]), qb);
			if (cand_dist < best_dist) begin
				best_dist  = cand_dist;
				best.index = i[INDEX_W-1:0];
			end
		end
		best.distance = best_dist[DIST_W-1:0];
		return best;
	endfunction

	// Presents one input transaction and waits for it to be taken. Valid is
	// lowered only for an idle gap, so a back-to-back transaction never sees
	// valid dropped and raised in the same time step.
	task automatic send_item(input logic req, input logic [INDEX_W-1:0] idx,
			input logic [CHAN6_W-1:0] r6, input logic [CHAN6_W-1:0] g6,
			input logic [CHAN6_W-1:0] b6, input logic [CHAN8_W-1:0] qr,
			input logic [CHAN8_W-1:0] qg, input logic [CHAN8_W-1:0] qb);
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= req;
		s_axis_tdata  <= {6'b0, qb, qg, qr, b6, g6, r6, idx};
		do @(posedge clk); while (!s_axis_tready);
		if (req == REQ_WRITE) begin
			if (int'(idx) < PAL_N)
				shade_table[idx] = {r6, g6, b6};
		end else begin
			pending_matches = {pending_matches, find_nearest(qr, qg, qb)};
		end
	endtask

	// The query fields of a write carry noise; the block must ignore them.
	task automatic write_entry(input logic [INDEX_W-1:0] idx, input logic [CHAN6_W-1:0] r6,
			input logic [CHAN6_W-1:0] g6, input logic [CHAN6_W-1:0] b6);
		send_item(REQ_WRITE, idx, r6, g6, b6,
			CHAN8_W'($urandom_range(255)), CHAN8_W'($urandom_range(255)),
			CHAN8_W'($urandom_range(255)));
	endtask

	// Likewise, the entry fields of a query carry noise.
	task automatic query_color(input logic [CHAN8_W-1:0] qr, input logic [CHAN8_W-1:0] qg,
			input logic [CHAN8_W-1:0] qb);
		send_item(REQ_QUERY, INDEX_W'($urandom_range(255)), CHAN6_W'($urandom_range(63)),
			CHAN6_W'($urandom_range(63)), CHAN6_W'($urandom_range(63)), qr, qg, qb);
	endtask

	task automatic hold_until_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_matches.size() != 0) @(posedge clk);
	endtask

	// Every entry is written to black before any query, so all reads are
	// defined from here on.
	task automatic test_palette_fill();
		for (int i = 0; i < PAL_N; i++)
			write_entry(i[INDEX_W-1:0], 6'd0, 6'd0, 6'd0);
	endtask

	task automatic test_extremes_and_ties();
		// All-black palette: white gives the largest distance, and every
		// entry ties, so index 1 must come back.
		query_color(8'd255, 8'd255, 8'd255);
		query_color(8'd0, 8'd0, 8'd0);
		// A perfect match in entry 0 must still lose to entry 1.
		write_entry(8'd0, 6'd63, 6'd63, 6'd63);
		query_color(8'd255, 8'd255, 8'd255);
		// Exact match at the top index, then an equal one lower down wins.
		write_entry(8'd255, 6'd63, 6'd63, 6'd63);
		query_color(8'd255, 8'd255, 8'd255);
		write_entry(8'd128, 6'd63, 6'd63, 6'd63);
		query_color(8'd255, 8'd255, 8'd255);
		// Mid-gray widens to 130, so a 128 query lands a small distance.
		write_entry(8'd2, 6'd32, 6'd32, 6'd32);
		query_color(8'd128, 8'd128, 8'd128);
		// Pure primaries at the channel extremes.
		write_entry(8'd3, 6'd0, 6'd63, 6'd0);
		query_color(8'd0, 8'd255, 8'd0);
		write_entry(8'd4, 6'd63, 6'd0, 6'd0);
		query_color(8'd255, 8'd0, 8'd0);
		write_entry(8'd5, 6'd0, 6'd0, 6'd63);
		query_color(8'd0, 8'd0, 8'd255);
	endtask

	function automatic logic [CHAN8_W-1:0] nudge(input logic [CHAN8_W-1:0] c);
		int v;
		v = int'(c) + int'($urandom_range(6)) - 3;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[CHAN8_W-1:0];
	endfunction

	// Mixed traffic. Some writes copy an existing entry to make ties likely,
	// and some queries sit close to a stored color so that the winner is
	// decided by small distances.
	task automatic test_random_traffic(input int n_items);
		logic [ENTRY_W-1:0] pick;
		int                 roll;
		for (int k = 0; k < n_items; k++) begin
			steady = (k >= 200 && k < 330);
			roll   = $urandom_range(99);
			if (roll < 10) begin
				pick = shade_table[INDEX_W'($urandom_range(PAL_N - 1))];
				write_entry(INDEX_W'($urandom_range(PAL_N - 1)), pick[17:12], pick[11:6],
					pick[5:0]);
			end else if (roll < 60) begin
				write_entry(INDEX_W'($urandom_range(PAL_N - 1)), CHAN6_W'($urandom_range(63)),
					CHAN6_W'($urandom_range(63)), CHAN6_W'($urandom_range(63)));
			end else if (roll < 80) begin
				query_color(CHAN8_W'($urandom_range(255)), CHAN8_W'($urandom_range(255)),
					CHAN8_W'($urandom_range(255)));
			end else begin
				pick = shade_table[INDEX_W'($urandom_range(1, PAL_N - 1))];
				query_color(nudge(widen_channel(pick[17:12])),
					nudge(widen_channel(pick[11:6])), nudge(widen_channel(pick[5:0])));
			end
		end
		steady = 1'b0;
	endtask

	// Output monitor: each result transaction is checked against the oldest
	// prediction. The receiver stalls at random outside the steady stretch.
	always @(posedge clk) begin
		color_match_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_matches.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
			end else begin
				want = pending_matches.pop_front();
				if (m_axis_tdata[7:0] !== want.index)
					report_mismatch($sformatf("best_index %0d, expected %0d",
						m_axis_tdata[7:0], want.index));
				if (m_axis_tdata[25:8] !== want.distance)
					report_mismatch($sformatf("best_distance %0d, expected %0d",
						m_axis_tdata[25:8], want.distance));
				if (m_axis_tdata[OUT_DATA_W-1:26] !== '0)
					report_mismatch($sformatf("padding bits set in %h", m_axis_tdata));
			end
		end
		m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	// Watchdog on cycles in which neither side moves a transaction.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("nearest_palette_color_search_tb failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_palette_fill();
		test_extremes_and_ties();
		hold_until_drained();
		test_random_traffic(580);
		hold_until_drained();
		// A settling wait, so a stray late result is caught.
		repeat (PAL_N + 16) @(posedge clk);
		if (pending_matches.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_matches.size()));
		if (error_count == 0)
			$display("nearest_palette_color_search_tb passed");
		else
			$display("nearest_palette_color_search_tb failed");
		$finish;
	end

endmodule
